[rtl/pvtsi_pkg.sv]
// ----------------------------------------------------------------------------
// PVT setpoint interpolator package
// Shared types, widths and saturation helpers for the interpolator blocks.
// ----------------------------------------------------------------------------
package pvtsi_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int TICKS_W         = 24;
  localparam int PVEL_W          = 32;
  localparam int PPOS_W          = 32;
  localparam int VEL_W           = 41;
  localparam int SLOPE_W         = 48;
  localparam int TICKCNT_W       = 32;
  localparam int PERIOD_W        = 32;
  localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST = 32'd214748;
  localparam int POINT_W         = TICKS_W + PVEL_W + PPOS_W;
  localparam int FIFO_DEPTH      = 2;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_TICK  = 2'd1,
    OP_GO    = 2'd2,
    OP_START = 2'd3
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [TICKS_W-1:0]  ticks;
    logic [PVEL_W-1:0]   velocity;
    logic [PPOS_W-1:0]   position;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GOLAT,
    S_CHK,
    S_LDRD,
    S_LDCV,
    S_DIV,
    S_TIME,
    S_MLO,
    S_MHI,
    S_VEL,
    S_TLO,
    S_THI,
    S_POS,
    S_OUT
  } state_t;

  localparam logic signed [79:0] MAX41 = 80'sd1099511627775;
  localparam logic signed [79:0] MIN41 = -80'sd1099511627776;

  function automatic logic signed [VEL_W-1:0] sat41(input logic signed [79:0] x);
    logic signed [VEL_W-1:0] r;
    if (x > MAX41) begin
      r = MAX41[VEL_W-1:0];
    end else if (x < MIN41) begin
      r = MIN41[VEL_W-1:0];
    end else begin
      r = x[VEL_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/pvtsi_front.sv]
// ----------------------------------------------------------------------------
// PVT interpolator front end
// Accepts input transactions, decodes the opcode and holds them in a short
// queue for the sequencer.
// ----------------------------------------------------------------------------
module pvtsi_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [pvtsi_pkg::POINT_W-1:0]         in_point,
  input  logic [1:0]                            in_opcode,
  output logic                                  item_valid,
  output pvtsi_pkg::item_t                      item,
  input  logic                                  item_pop
);

  pvtsi_pkg::item_t slot_r [pvtsi_pkg::FIFO_DEPTH];
  logic             wptr_r;
  logic             rptr_r;
  logic [1:0]       count_r;
  logic             push;
  logic             pop;
  pvtsi_pkg::item_t decoded;

  always_comb begin
    decoded.op       = pvtsi_pkg::op_t'(in_opcode);
    decoded.ticks    = in_point[pvtsi_pkg::TICKS_W-1:0];
    decoded.velocity = in_point[pvtsi_pkg::TICKS_W +: pvtsi_pkg::PVEL_W];
    decoded.position = in_point[pvtsi_pkg::TICKS_W + pvtsi_pkg::PVEL_W +: pvtsi_pkg::PPOS_W];
  end

  assign in_tready  = (count_r != 2'(pvtsi_pkg::FIFO_DEPTH));
  assign item_valid = (count_r != 2'd0);
  assign item       = slot_r[rptr_r];
  assign push       = in_tvalid && in_tready;
  assign pop        = item_pop && item_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

endmodule

[rtl/pvtsi_back.sv]
// ----------------------------------------------------------------------------
// PVT interpolator back end
// Sequencer that holds the point memory, loads segments through a serial
// divider, interpolates with split multiplies and registers the result.
// ----------------------------------------------------------------------------
module pvtsi_back #(
  parameter int QUEUE_DEPTH = pvtsi_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [pvtsi_pkg::PERIOD_W-1:0]        cfg_wdata,
  input  logic                                  item_valid,
  input  pvtsi_pkg::item_t                      item,
  output logic                                  item_pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [pvtsi_pkg::VEL_W-1:0]    res_position,
  output logic signed [pvtsi_pkg::VEL_W-1:0]    res_velocity,
  output logic                                  res_active,
  output logic                                  res_playing,
  output logic [pvtsi_pkg::PPOS_W-1:0]          res_target,
  output logic                                  res_dropped
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int VW    = pvtsi_pkg::VEL_W;
  localparam int TW    = pvtsi_pkg::TICKS_W;
  localparam int SW    = pvtsi_pkg::SLOPE_W;
  localparam int CW    = pvtsi_pkg::TICKCNT_W;

  pvtsi_pkg::state_t state_r, state_nxt;

  logic [pvtsi_pkg::POINT_W-1:0] mem [QUEUE_DEPTH];
  logic [pvtsi_pkg::POINT_W-1:0] rd_q;
  logic                          mem_we;
  logic [PTR_W-1:0]              mem_ra;

  logic [pvtsi_pkg::PERIOD_W-1:0] period_r;
  logic [PTR_W-1:0]               head_r, tail_r, tail_prev, head_inc, tail_inc;
  logic [CNT_W-1:0]               count_r;
  logic [CW-1:0]                  tick_r, seg_start_r, seg_end_r;
  logic signed [VW-1:0]           start_vel_r, end_vel_r;
  logic signed [SW-1:0]           slope_r;
  logic [pvtsi_pkg::PPOS_W-1:0]   seg_pos_r, target_r;
  logic                           go_r, active_r;

  pvtsi_pkg::item_t               cur_r;
  logic [TW-1:0]                  dur_r;
  logic signed [64:0]             prod_r;
  logic [SW-1:0]                  dvd_r;
  logic [TW-1:0]                  rem_r;
  logic [5:0]                     dcnt_r;
  logic                           neg_r;
  logic [TW-1:0]                  t_r, dd_r, r_r;
  logic signed [72:0]             acc_r;
  logic signed [VW-1:0]           v_r;
  logic signed [VW:0]             sum_r;
  logic signed [67:0]             acc2_r;
  logic signed [VW-1:0]           res_s_r, res_v_r;
  logic                           res_seg_r, drop_r;

  logic signed [VW-1:0]           ev_new;
  logic signed [VW:0]             vdiff;
  logic [SW-1:0]                  vdiff_mag;
  logic [TW:0]                    trial;
  logic                           trial_ge;
  logic [CW-1:0]                  d32, t32;
  logic [TW-1:0]                  t_clamp;
  logic signed [VW-1:0]           v_new;
  logic signed [VW-1:0]           s_new;
  logic                           q_full, q_empty;

  assign q_full    = (count_r >= CNT_W'(QUEUE_DEPTH));
  assign q_empty   = (count_r == '0);
  assign head_inc  = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc  = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign tail_prev = (tail_r == '0) ? PTR_W'(QUEUE_DEPTH - 1) : tail_r - 1'b1;

  assign ev_new    = pvtsi_pkg::sat41(80'((prod_r + 65'sd128) >>> 8));
  assign vdiff     = (VW+1)'(ev_new) - (VW+1)'(start_vel_r);
  assign vdiff_mag = vdiff[VW] ? SW'(-vdiff) << 6 : SW'(vdiff) << 6;
  assign trial     = {rem_r, dvd_r[SW-1]};
  assign trial_ge  = (trial >= {1'b0, dur_r});
  assign d32       = seg_end_r - seg_start_r;
  assign t32       = tick_r - seg_start_r;
  assign t_clamp   = (t32 > d32) ? d32[TW-1:0] : t32[TW-1:0];
  assign v_new     = pvtsi_pkg::sat41(80'(acc_r >>> 6) + 80'(start_vel_r));
  assign s_new     = pvtsi_pkg::sat41(80'({seg_pos_r, 8'd0}) - 80'(acc2_r >>> 17));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pvtsi_pkg::S_IDLE: begin
        if (item_valid) begin
          unique case (item.op)
            pvtsi_pkg::OP_TICK: state_nxt = pvtsi_pkg::S_CHK;
            pvtsi_pkg::OP_GO:
              state_nxt = (!go_r && !q_empty) ? pvtsi_pkg::S_GOLAT : pvtsi_pkg::S_OUT;
            default: state_nxt = pvtsi_pkg::S_OUT;
          endcase
        end
      end
      pvtsi_pkg::S_GOLAT: state_nxt = pvtsi_pkg::S_OUT;
      pvtsi_pkg::S_CHK: begin
        if (go_r && !active_r && !q_empty) begin
          state_nxt = pvtsi_pkg::S_LDRD;
        end else if (active_r) begin
          state_nxt = pvtsi_pkg::S_TIME;
        end else begin
          state_nxt = pvtsi_pkg::S_OUT;
        end
      end
      pvtsi_pkg::S_LDRD: state_nxt = pvtsi_pkg::S_LDCV;
      pvtsi_pkg::S_LDCV:
        state_nxt = (dur_r == '0) ? pvtsi_pkg::S_CHK : pvtsi_pkg::S_DIV;
      pvtsi_pkg::S_DIV:
        state_nxt = (dcnt_r == 6'(SW - 1)) ? pvtsi_pkg::S_CHK : pvtsi_pkg::S_DIV;
      pvtsi_pkg::S_TIME: state_nxt = pvtsi_pkg::S_MLO;
      pvtsi_pkg::S_MLO:  state_nxt = pvtsi_pkg::S_MHI;
      pvtsi_pkg::S_MHI:  state_nxt = pvtsi_pkg::S_VEL;
      pvtsi_pkg::S_VEL:  state_nxt = pvtsi_pkg::S_TLO;
      pvtsi_pkg::S_TLO:  state_nxt = pvtsi_pkg::S_THI;
      pvtsi_pkg::S_THI:  state_nxt = pvtsi_pkg::S_POS;
      pvtsi_pkg::S_POS:  state_nxt = pvtsi_pkg::S_OUT;
      pvtsi_pkg::S_OUT:
        state_nxt = (!out_valid || out_ready) ? pvtsi_pkg::S_IDLE : pvtsi_pkg::S_OUT;
      default: state_nxt = pvtsi_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    item_pop = 1'b0;
    mem_we   = 1'b0;
    mem_ra   = head_r;
    unique case (state_r)
      pvtsi_pkg::S_IDLE: begin
        item_pop = item_valid;
        mem_we   = item_valid && (item.op == pvtsi_pkg::OP_PUSH) && !q_full;
        mem_ra   = tail_prev;
      end
      default: begin
        mem_ra = head_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_r] <= {item.position, item.velocity, item.ticks};
    end
    rd_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pvtsi_pkg::S_IDLE;
      period_r    <= pvtsi_pkg::TICK_PERIOD_RST;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      tick_r      <= '0;
      seg_start_r <= '0;
      seg_end_r   <= '0;
      start_vel_r <= '0;
      end_vel_r   <= '0;
      slope_r     <= '0;
      seg_pos_r   <= '0;
      target_r    <= '0;
      go_r        <= 1'b0;
      active_r    <= 1'b0;
      out_valid   <= 1'b0;
      drop_r      <= 1'b0;
      dcnt_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        period_r <= cfg_wdata;
      end
      if (state_r == pvtsi_pkg::S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        pvtsi_pkg::S_IDLE: begin
          if (item_valid) begin
            cur_r  <= item;
            drop_r <= (item.op == pvtsi_pkg::OP_PUSH) && q_full;
            unique case (item.op)
              pvtsi_pkg::OP_PUSH: begin
                if (!q_full) begin
                  tail_r  <= tail_inc;
                  count_r <= count_r + 1'b1;
                end
              end
              pvtsi_pkg::OP_TICK: begin
                if (q_empty) begin
                  go_r <= 1'b0;
                end
              end
              pvtsi_pkg::OP_GO: begin
                go_r <= 1'b1;
              end
              default: begin
                head_r      <= '0;
                tail_r      <= '0;
                count_r     <= '0;
                tick_r      <= '0;
                seg_start_r <= '0;
                seg_end_r   <= '0;
                start_vel_r <= '0;
                end_vel_r   <= '0;
                slope_r     <= '0;
                seg_pos_r   <= item.position;
                target_r    <= item.position;
                go_r        <= 1'b0;
                active_r    <= 1'b0;
              end
            endcase
          end
        end
        pvtsi_pkg::S_GOLAT: begin
          target_r <= rd_q[TW + pvtsi_pkg::PVEL_W +: pvtsi_pkg::PPOS_W];
        end
        pvtsi_pkg::S_CHK: begin
          if (!(go_r && !active_r && !q_empty) && !active_r) begin
            res_s_r   <= {1'b0, seg_pos_r, 8'd0};
            res_v_r   <= '0;
            res_seg_r <= 1'b0;
            tick_r    <= tick_r + 1'b1;
          end
        end
        pvtsi_pkg::S_LDRD: begin
          dur_r       <= rd_q[TW-1:0];
          seg_start_r <= tick_r;
          seg_end_r   <= tick_r + CW'(rd_q[TW-1:0]);
          start_vel_r <= end_vel_r;
          seg_pos_r   <= rd_q[TW + pvtsi_pkg::PVEL_W +: pvtsi_pkg::PPOS_W];
          prod_r      <= 65'($signed(rd_q[TW +: pvtsi_pkg::PVEL_W]))
                         * $signed({1'b0, period_r});
        end
        pvtsi_pkg::S_LDCV: begin
          end_vel_r <= ev_new;
          if (dur_r == '0) begin
            head_r  <= head_inc;
            count_r <= count_r - 1'b1;
          end else begin
            dvd_r  <= vdiff_mag;
            rem_r  <= '0;
            neg_r  <= vdiff[VW];
            dcnt_r <= '0;
          end
        end
        pvtsi_pkg::S_DIV: begin
          rem_r  <= trial_ge ? TW'(trial - {1'b0, dur_r}) : trial[TW-1:0];
          dvd_r  <= {dvd_r[SW-2:0], trial_ge};
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == 6'(SW - 1)) begin
            slope_r  <= neg_r ? -$signed({dvd_r[SW-2:0], trial_ge})
                              : $signed({dvd_r[SW-2:0], trial_ge});
            active_r <= 1'b1;
          end
        end
        pvtsi_pkg::S_TIME: begin
          t_r  <= t_clamp;
          dd_r <= d32[TW-1:0];
        end
        pvtsi_pkg::S_MLO: begin
          acc_r <= 73'($unsigned(slope_r[TW-1:0]) * t_r);
        end
        pvtsi_pkg::S_MHI: begin
          acc_r <= acc_r + (73'($signed(slope_r[SW-1:TW]) * $signed({1'b0, t_r})) <<< TW);
        end
        pvtsi_pkg::S_VEL: begin
          v_r   <= v_new;
          sum_r <= (VW+1)'(v_new) + (VW+1)'(end_vel_r);
          r_r   <= dd_r - t_r;
        end
        pvtsi_pkg::S_TLO: begin
          acc2_r <= 68'($unsigned(sum_r[20:0]) * r_r);
        end
        pvtsi_pkg::S_THI: begin
          acc2_r <= acc2_r + (68'($signed(sum_r[VW:21]) * $signed({1'b0, r_r})) <<< 21);
        end
        pvtsi_pkg::S_POS: begin
          res_s_r   <= s_new;
          res_v_r   <= v_r;
          res_seg_r <= 1'b1;
          tick_r    <= tick_r + 1'b1;
          if (t_r >= dd_r) begin
            head_r   <= head_inc;
            count_r  <= count_r - 1'b1;
            slope_r  <= '0;
            active_r <= 1'b0;
          end
        end
        default: begin
          dcnt_r <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == pvtsi_pkg::S_OUT && (!out_valid || out_ready)) begin
      if (cur_r.op == pvtsi_pkg::OP_TICK) begin
        res_position <= res_s_r;
        res_velocity <= res_v_r;
        res_active   <= res_seg_r;
      end else begin
        res_position <= '0;
        res_velocity <= '0;
        res_active   <= active_r;
      end
      res_playing <= go_r;
      res_target  <= target_r;
      res_dropped <= drop_r;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("point queue count exceeds depth");
  a_active_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> !q_empty)
    else $error("segment active with empty point queue");
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pvtsi_pkg::S_DIV |=> state_r == pvtsi_pkg::S_DIV || state_r == pvtsi_pkg::S_CHK)
    else $error("divider left to an unexpected state");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pvtsi_pkg::S_OUT && out_valid && !out_ready |=> state_r == pvtsi_pkg::S_OUT)
    else $error("result overwritten while stalled");
`endif

endmodule

[rtl/pvt_setpoint_interpolator.sv]
// ----------------------------------------------------------------------------
// PVT setpoint interpolator
// Usage: items enter on the in_ stream; opcode travels in in_tuser, and the
// point duration, velocity and position in in_tdata. Each item yields one
// result transaction on the out_ stream. The tick period is written through
// the cfg_ channel, which is always ready; the user must write it only while
// the block is idle; the block does not enforce this. A two-entry input queue
// lets the front accept while the sequencer works. Push and start go straight
// to the result; go may first latch the target. In playback a tick loads
// queued points; each non-zero-duration one passes the one-bit-per-cycle
// slope divider; split multiplies give a playing segment's setpoints. The
// sequencer takes the next item in the cycle after a result is registered.
// Results wait in the output register while out_tready is low; the sequencer
// then holds and the input queue fills and drops in_tready. Synchronous reset
// clears queue, playback state and tick period (to default); no clearing pass.
// ----------------------------------------------------------------------------
module pvt_setpoint_interpolator #(
  parameter int QUEUE_DEPTH = pvtsi_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // point_ticks[23:0], point_velocity[55:24], point_position[87:56]
  input  logic [87:0]   in_tdata,
  // opcode[1:0]
  input  logic [1:0]    in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // position_setpoint[40:0], velocity_feedforward[81:41], segment_active[82],
  // playing[83], target_position[115:84], push_dropped[116], zero[119:117]
  output logic [119:0]  out_tdata,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [31:0]   cfg_data
);

  logic                                     item_valid;
  logic                                     item_pop;
  pvtsi_pkg::item_t                         item;
  logic signed [pvtsi_pkg::VEL_W-1:0]       res_position, res_velocity;
  logic                                     res_active, res_playing, res_dropped;
  logic [pvtsi_pkg::PPOS_W-1:0]             res_target;

  assign cfg_ready = 1'b1;

  pvtsi_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_point   (in_tdata),
    .in_opcode  (in_tuser),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  pvtsi_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_wdata    (cfg_data),
    .item_valid   (item_valid),
    .item         (item),
    .item_pop     (item_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .res_position (res_position),
    .res_velocity (res_velocity),
    .res_active   (res_active),
    .res_playing  (res_playing),
    .res_target   (res_target),
    .res_dropped  (res_dropped)
  );

  assign out_tdata = {3'b000, res_dropped, res_target, res_playing, res_active,
                      res_velocity, res_position};

endmodule
